@@ hdl/msm_pkg.sv @@
`timescale 1ns / 1ps

package msm_pkg;

    localparam int NUM_CHANNELS = 5;
    localparam int CH_W = 3;
    localparam int POS_W = 8;
    localparam int REQ_W = 2;

    typedef logic [CH_W-1:0]  t_ch;
    typedef logic [POS_W-1:0] t_pos;
    typedef logic [REQ_W-1:0] t_req;

    localparam t_req REQ_TICK       = 2'd0;
    localparam t_req REQ_SET_TARGET = 2'd1;
    localparam t_req REQ_MOVE       = 2'd2;

    localparam t_pos POS_MAX = 8'd180;

    // floor(nv * span / 180) == (nv * ceil(span * 2^24 / 180)) >> 24 for nv <= 180
    localparam int MAP_SHIFT = 24;
    localparam int MULT_W = 25;

    localparam logic [MULT_W-1:0] MULT_SPAN_90  =
        MULT_W'(((64'd90  << MAP_SHIFT) + 64'd179) / 64'd180);
    localparam logic [MULT_W-1:0] MULT_SPAN_110 =
        MULT_W'(((64'd110 << MAP_SHIFT) + 64'd179) / 64'd180);
    localparam logic [MULT_W-1:0] MULT_SPAN_120 =
        MULT_W'(((64'd120 << MAP_SHIFT) + 64'd179) / 64'd180);

    localparam t_pos CH_MIN [NUM_CHANNELS] = '{8'd70, 8'd0, 8'd0, 8'd0, 8'd90};
    localparam logic [MULT_W-1:0] CH_MULT [NUM_CHANNELS] =
        '{MULT_SPAN_110, MULT_SPAN_120, MULT_SPAN_120, MULT_SPAN_120, MULT_SPAN_90};
    localparam logic CH_REV [NUM_CHANNELS] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
    // servo angle for virtual position 0
    localparam t_pos CH_RESET_REAL [NUM_CHANNELS] =
        '{8'd180, 8'd0, 8'd0, 8'd0, 8'd180};

    // Virtual (0..180) to real servo angle; the result never leaves [min, max].
    function automatic t_pos map_real(input t_ch ch, input t_pos v);
        t_pos nv;
        logic [MULT_W+POS_W-1:0] prod;
        nv = CH_REV[ch] ? POS_MAX - v : v;
        prod = {{MULT_W{1'b0}}, nv} * {{POS_W{1'b0}}, CH_MULT[ch]};
        return prod[MAP_SHIFT +: POS_W] + CH_MIN[ch];
    endfunction

endpackage

@@ hdl/msm_req_if.sv @@
`timescale 1ns / 1ps

interface msm_req_if;
    import msm_pkg::*;

    logic valid;
    logic ready;
    t_req req_type;
    t_ch  channel;
    t_pos position;
    logic target_enable;

    modport source (
        output valid, req_type, channel, position, target_enable,
        input  ready
    );
    modport sink (
        input  valid, req_type, channel, position, target_enable,
        output ready
    );
endinterface

@@ hdl/msm_res_if.sv @@
`timescale 1ns / 1ps

interface msm_res_if;
    import msm_pkg::*;

    logic valid;
    logic ready;
    t_ch  out_channel;
    t_pos real_position;
    t_pos virtual_position;
    logic last;

    modport source (
        output valid, out_channel, real_position, virtual_position, last,
        input  ready
    );
    modport sink (
        input  valid, out_channel, real_position, virtual_position, last,
        output ready
    );
endinterface

@@ hdl/multichannel_servo_slew_mapper_unit.sv @@
`timescale 1ns / 1ps
// A request moves from the request register to the per-channel write buffer, then
// to the output register. One request per cycle while each causes at most one write
// and the output is not stalled; a tick causing k writes (k <= 5) holds the request
// register while the single output port drains the buffer one entry per ready cycle.
// Reset (synchronous, active low): virtual positions 0, real angles to their mapped
// rest values, targets cleared and disabled, step size 1, all queues empty.
module multichannel_servo_slew_mapper_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [msm_pkg::POS_W-1:0] i_cfg_wdata,
    msm_req_if.sink                   i_req,
    msm_res_if.source                 o_res
);
    import msm_pkg::*;

    t_pos r_step;

    t_pos r_virt [NUM_CHANNELS];
    t_pos r_real [NUM_CHANNELS];
    t_pos r_tgt [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_tgt_vld;

    // request register
    logic r_in_vld;
    t_req r_in_type;
    t_ch  r_in_ch;
    t_pos r_in_pos;
    logic r_in_en;

    // pending writes, one slot per channel
    logic [NUM_CHANNELS-1:0] r_buf_mask;
    logic [NUM_CHANNELS-1:0] n_buf_mask;
    t_pos r_buf_real [NUM_CHANNELS];
    t_pos r_buf_virt [NUM_CHANNELS];

    // output register
    logic r_out_vld;
    t_ch  r_out_ch;
    t_pos r_out_real;
    t_pos r_out_virt;
    logic r_out_last;

    logic out_free;
    logic buf_free;
    logic process;
    logic [NUM_CHANNELS-1:0] buf_low;
    t_ch  buf_sel;

    t_pos pos_sat;
    logic is_tick;
    logic is_set;
    logic is_move;
    logic [NUM_CHANNELS-1:0] ch_hit;
    logic [NUM_CHANNELS-1:0] upd;
    logic [NUM_CHANNELS-1:0] emit;
    t_pos new_v [NUM_CHANNELS];
    t_pos new_r [NUM_CHANNELS];

    assign out_free = !r_out_vld || o_res.ready;
    // buffer can take a new load if it is empty or its only entry leaves now
    assign buf_free = ((r_buf_mask & (r_buf_mask - 1'b1)) == '0)
                      && ((r_buf_mask == '0) || out_free);
    assign process = r_in_vld && buf_free;
    assign i_req.ready = !r_in_vld || process;

    assign buf_low = r_buf_mask & (~r_buf_mask + 1'b1);

    always_comb begin
        buf_sel = '0;
        for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
            if (r_buf_mask[i]) begin
                buf_sel = CH_W'(i);
            end
        end
    end

    assign pos_sat = (r_in_pos > POS_MAX) ? POS_MAX : r_in_pos;
    assign is_tick = (r_in_type == REQ_TICK);
    assign is_set  = (r_in_type == REQ_SET_TARGET);
    assign is_move = (r_in_type == REQ_MOVE);

    always_comb begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            logic up;
            logic moving;
            logic snap;
            t_pos gap;
            t_pos stepped;
            up = r_tgt[i] > r_virt[i];
            gap = up ? r_tgt[i] - r_virt[i] : r_virt[i] - r_tgt[i];
            moving = r_tgt_vld[i] && (r_virt[i] != r_tgt[i]);
            // snap when the distance left after one step is at most one step
            snap = {1'b0, gap} <= {r_step, 1'b0};
            if (snap) begin
                stepped = r_tgt[i];
            end else if (up) begin
                stepped = r_virt[i] + r_step;
            end else begin
                stepped = r_virt[i] - r_step;
            end
            ch_hit[i] = (r_in_ch == CH_W'(i));
            new_v[i] = is_move ? pos_sat : stepped;
            upd[i] = (is_tick && moving) || (is_move && ch_hit[i]);
            new_r[i] = map_real(CH_W'(i), new_v[i]);
            emit[i] = upd[i] && (new_r[i] != r_real[i]);
        end
    end

    always_comb begin
        if (process) begin
            n_buf_mask = emit;
        end else if (out_free) begin
            n_buf_mask = r_buf_mask & ~buf_low;
        end else begin
            n_buf_mask = r_buf_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 8'd1;
            r_in_vld <= 1'b0;
            r_buf_mask <= '0;
            r_out_vld <= 1'b0;
            r_tgt_vld <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_virt[i] <= '0;
                r_real[i] <= CH_RESET_REAL[i];
                r_tgt[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_step <= i_cfg_wdata;
            end
            if (i_req.ready) begin
                r_in_vld <= i_req.valid;
            end
            r_buf_mask <= n_buf_mask;
            if (out_free) begin
                r_out_vld <= |r_buf_mask;
            end
            if (process) begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    if (upd[i]) begin
                        r_virt[i] <= new_v[i];
                        r_real[i] <= new_r[i];
                    end
                    if (ch_hit[i] && is_move) begin
                        r_tgt_vld[i] <= 1'b0;
                    end
                    if (ch_hit[i] && is_set) begin
                        r_tgt_vld[i] <= r_in_en;
                        if (r_in_en) begin
                            r_tgt[i] <= pos_sat;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_type <= i_req.req_type;
            r_in_ch <= i_req.channel;
            r_in_pos <= i_req.position;
            r_in_en <= i_req.target_enable;
        end
        if (process) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                if (emit[i]) begin
                    r_buf_real[i] <= new_r[i];
                    r_buf_virt[i] <= new_v[i];
                end
            end
        end
        if (out_free) begin
            r_out_ch <= buf_sel;
            r_out_real <= r_buf_real[buf_sel];
            r_out_virt <= r_buf_virt[buf_sel];
            r_out_last <= ((r_buf_mask & ~buf_low) == '0);
        end
    end

    assign o_res.valid = r_out_vld;
    assign o_res.out_channel = r_out_ch;
    assign o_res.real_position = r_out_real;
    assign o_res.virtual_position = r_out_virt;
    assign o_res.last = r_out_last;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import msm_pkg::*;

    localparam t_req REQ_UNUSED  = 2'd3;
    localparam int   FULL_SWING  = 180;
    localparam int   QUIET_LIMIT = 4000;
    localparam int   DRAIN_WAIT  = 4;
    localparam int   PHASE_ITEMS = 15;

    // per-channel servo travel: (min, max, mirrored)
    localparam int SERVO_MIN [NUM_CHANNELS] = '{70, 0, 0, 0, 90};
    localparam int SERVO_MAX [NUM_CHANNELS] = '{180, 120, 120, 120, 180};
    localparam bit SERVO_REV [NUM_CHANNELS] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1};

    typedef struct {
        t_req kind;
        t_ch  ch;
        t_pos pos;
        logic en;
    } t_servo_req;

    typedef struct {
        t_ch  ch;
        t_pos real_deg;
        t_pos virt_deg;
        logic last;
    } t_servo_write;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [POS_W-1:0] cfg_wdata;

    msm_req_if req_if ();
    msm_res_if res_if ();

    multichannel_servo_slew_mapper_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .o_res       (res_if)
    );

    t_servo_req   req_backlog [$];
    t_servo_write pending_writes [$];

    // shadow state of the servo bank
    int virt_pos [NUM_CHANNELS];
    int real_deg [NUM_CHANNELS];
    int tgt_pos  [NUM_CHANNELS];
    bit tgt_on   [NUM_CHANNELS];
    int step_deg;

    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_cnt;
    int quiet_cycles;
    t_servo_req in_flight;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int servo_angle(input int ch, input int v);
        int nv;
        int r;
        nv = SERVO_REV[ch] ? FULL_SWING - v : v;
        r = nv * (SERVO_MAX[ch] - SERVO_MIN[ch]) / FULL_SWING + SERVO_MIN[ch];
        if (r < SERVO_MIN[ch]) r = SERVO_MIN[ch];
        if (r > SERVO_MAX[ch]) r = SERVO_MAX[ch];
        return r;
    endfunction

    task automatic reset_servo_bank();
        step_deg = 1;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            virt_pos[i] = 0;
            tgt_pos[i]  = 0;
            tgt_on[i]   = 1'b0;
            real_deg[i] = servo_angle(i, 0);
        end
    endtask

    task automatic predict_servo_writes(input t_servo_req r);
        int mv_ch [NUM_CHANNELS];
        int mv_v  [NUM_CHANNELS];
        t_servo_write batch [NUM_CHANNELS];
        int m;
        int n;
        int pos;
        int nxt;
        int gap;
        int angle;
        m = 0;
        n = 0;
        pos = (r.pos > FULL_SWING) ? FULL_SWING : int'(r.pos);
        case (r.kind)
            REQ_TICK: begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    if (tgt_on[i] && virt_pos[i] != tgt_pos[i]) begin
                        nxt = virt_pos[i] + ((tgt_pos[i] > virt_pos[i]) ? step_deg : -step_deg);
                        gap = (tgt_pos[i] > nxt) ? tgt_pos[i] - nxt : nxt - tgt_pos[i];
                        mv_ch[m] = i;
                        mv_v[m] = (gap <= step_deg) ? tgt_pos[i] : nxt;
                        m++;
                    end
                end
            end
            REQ_SET_TARGET: begin
                if (r.ch < NUM_CHANNELS) begin
                    if (r.en) begin
                        tgt_pos[r.ch] = pos;
                        tgt_on[r.ch] = 1'b1;
                    end else begin
                        tgt_on[r.ch] = 1'b0;
                    end
                end
            end
            REQ_MOVE: begin
                if (r.ch < NUM_CHANNELS) begin
                    mv_ch[0] = r.ch;
                    mv_v[0] = pos;
                    m = 1;
                    tgt_on[r.ch] = 1'b0;
                end
            end
            default: ;
        endcase
        for (int k = 0; k < m; k++) begin
            angle = servo_angle(mv_ch[k], mv_v[k]);
            virt_pos[mv_ch[k]] = mv_v[k];
            if (angle != real_deg[mv_ch[k]]) begin
                real_deg[mv_ch[k]] = angle;
                batch[n].ch = t_ch'(mv_ch[k]);
                batch[n].real_deg = t_pos'(angle);
                batch[n].virt_deg = t_pos'(mv_v[k]);
                batch[n].last = 1'b0;
                n++;
            end
        end
        for (int k = 0; k < n; k++) begin
            batch[k].last = (k == n - 1);
            pending_writes.push_back(batch[k]);
        end
    endtask

    task automatic push_req(input t_req kind, input int ch, input int pos, input bit en);
        t_servo_req r;
        r.kind = kind;
        r.ch = t_ch'(ch);
        r.pos = t_pos'(pos);
        r.en = en;
        req_backlog.push_back(r);
    endtask

    // mostly well-formed traffic; a tenth is requests the block must ignore
    task automatic push_random_phase(input int count);
        t_servo_req r;
        int roll;
        int done;
        done = 0;
        while (done < count) begin
            roll = $urandom_range(99);
            r.ch = t_ch'($urandom_range(0, NUM_CHANNELS - 1));
            r.pos = ($urandom_range(99) < 10) ? t_pos'($urandom_range(181, 255))
                                              : t_pos'($urandom_range(0, FULL_SWING));
            r.en = ($urandom_range(99) < 85);
            if (roll < 40) begin
                r.kind = REQ_TICK;
                r.ch = t_ch'($urandom_range(0, 7));
                r.en = 1'($urandom_range(1));
            end else if (roll < 70) begin
                r.kind = REQ_SET_TARGET;
            end else if (roll < 90) begin
                r.kind = REQ_MOVE;
            end else begin
                r.kind = t_req'($urandom_range(1, 3));
                r.ch = t_ch'($urandom_range(NUM_CHANNELS, 7));
                r.pos = t_pos'($urandom_range(0, 255));
            end
            req_backlog.push_back(r);
            if (r.kind == REQ_TICK || (r.kind != REQ_UNUSED && r.ch < NUM_CHANNELS))
                done++;
        end
    endtask

    task automatic wait_quiet();
        do @(negedge clk);
        while (req_backlog.size() != 0 || req_if.valid || pending_writes.size() != 0);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_step(input int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= POS_W'(value);
        step_deg = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // request driver
    always @(posedge clk) begin : req_driver
        if (!rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready)
                predict_servo_writes(in_flight);
            if (!req_if.valid || req_if.ready) begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_flight = req_backlog.pop_front();
                    req_if.valid <= 1'b1;
                    req_if.req_type <= in_flight.kind;
                    req_if.channel <= in_flight.ch;
                    req_if.position <= in_flight.pos;
                    req_if.target_enable <= in_flight.en;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // servo write monitor
    always @(posedge clk) begin : write_monitor
        t_servo_write want;
        if (!rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (pending_writes.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: unexpected write ch=%0d real=%0d virt=%0d last=%0b",
                                 $time, res_if.out_channel, res_if.real_position,
                                 res_if.virtual_position, res_if.last);
                end else begin
                    want = pending_writes.pop_front();
                    if (res_if.out_channel !== want.ch || res_if.real_position !== want.real_deg
                        || res_if.virtual_position !== want.virt_deg
                        || res_if.last !== want.last) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("%0t: write mismatch exp ch/real/virt/last=%0d/%0d/%0d/%0b",
                                     $time, want.ch, want.real_deg, want.virt_deg, want.last,
                                     " got %0d/%0d/%0d/%0b",
                                     res_if.out_channel, res_if.real_position,
                                     res_if.virtual_position, res_if.last);
                    end
                end
            end
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin : watchdog
        if (rst_n) begin
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
                $display("** multichannel_servo_slew_mapper_unit: FAILED **");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int phase_step [5];
        int phase_send [5];
        int phase_recv [5];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_if.valid = 1'b0;
        req_if.req_type = REQ_TICK;
        req_if.channel = '0;
        req_if.position = '0;
        req_if.target_enable = 1'b0;
        res_if.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatch_cnt = 0;
        quiet_cycles = 0;
        reset_servo_bank();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: nothing armed, saturation, unchanged angles, ignored requests
        push_req(REQ_TICK, 0, 0, 0);
        push_req(REQ_MOVE, 0, 180, 0);
        push_req(REQ_MOVE, 0, 180, 0);
        push_req(REQ_MOVE, 4, 0, 1);
        push_req(REQ_MOVE, 1, 255, 1);
        push_req(REQ_MOVE, 2, 1, 0);
        push_req(REQ_MOVE, 3, 3, 0);
        push_req(REQ_MOVE, 7, 90, 1);
        push_req(REQ_SET_TARGET, 5, 10, 1);
        push_req(REQ_UNUSED, 3, 200, 1);
        push_req(REQ_SET_TARGET, 0, 0, 1);
        push_req(REQ_SET_TARGET, 1, 181, 1);
        push_req(REQ_SET_TARGET, 2, 90, 1);
        push_req(REQ_SET_TARGET, 3, 0, 1);
        push_req(REQ_SET_TARGET, 4, 180, 1);
        push_req(REQ_TICK, 0, 0, 0);
        push_req(REQ_TICK, 7, 255, 1);
        push_req(REQ_SET_TARGET, 2, 0, 0);
        push_req(REQ_TICK, 0, 0, 0);
        push_req(REQ_MOVE, 0, 100, 0);
        push_req(REQ_TICK, 0, 0, 0);
        wait_quiet();
        // zero step: ticks leave every channel where it is
        write_step(0);
        push_req(REQ_TICK, 0, 0, 0);
        push_req(REQ_TICK, 0, 0, 0);
        wait_quiet();
        // full-range step snaps straight onto the target
        write_step(FULL_SWING);
        push_req(REQ_TICK, 0, 0, 0);
        push_req(REQ_SET_TARGET, 3, 180, 1);
        push_req(REQ_TICK, 0, 0, 0);
        wait_quiet();

        phase_step = '{FULL_SWING, 1, $urandom_range(2, 12), $urandom_range(13, 179), 3};
        phase_send = '{0, 59, 0, 25, 0};
        phase_recv = '{0, 0, 59, 25, 0};
        for (int p = 0; p < 5; p++) begin
            write_step(phase_step[p]);
            send_idle_pct = phase_send[p];
            recv_stall_pct = phase_recv[p];
            push_random_phase(PHASE_ITEMS);
            wait_quiet();
        end

        repeat (10) @(negedge clk);
        if (mismatch_cnt == 0 && pending_writes.size() == 0) begin
            $display("** multichannel_servo_slew_mapper_unit: PASSED **");
        end else begin
            if (pending_writes.size() != 0)
                $display("%0d expected writes never arrived", pending_writes.size());
            $display("** multichannel_servo_slew_mapper_unit: FAILED **");
        end
        $finish;
    end

endmodule

@@ multichannel_servo_slew_mapper_unit.f @@
hdl/msm_pkg.sv
hdl/msm_req_if.sv
hdl/msm_res_if.sv
hdl/multichannel_servo_slew_mapper_unit.sv
bench/testbench.sv
